/* hdl/line_sensor_pd_steering_assert.svh */
// Assertion macros used by the checker file.
`ifndef LINE_SENSOR_PD_STEERING_ASSERT_SVH
`define LINE_SENSOR_PD_STEERING_ASSERT_SVH

// Implication checked on every rising clock edge outside reset.
`define LSPD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Implication checked in the cycle after the antecedent.
`define LSPD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* hdl/lsp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package lsp_pkg;
  localparam int unsigned NumSensorsDef = 8;
  localparam int unsigned SampleBitsDef = 10;
  localparam int unsigned CfgIdxBits = 3;
  localparam int unsigned CfgDataBits = 8;

  localparam logic [CfgIdxBits-1:0] RegPropGain = 3'd0;
  localparam logic [CfgIdxBits-1:0] RegDerivGain = 3'd1;
  localparam logic [CfgIdxBits-1:0] RegTarget = 3'd2;
  localparam logic [CfgIdxBits-1:0] RegMaxSpeed = 3'd3;
  localparam logic [CfgIdxBits-1:0] RegPercent = 3'd4;

  localparam logic [1:0] ModeForward = 2'd0;
  localparam logic [1:0] ModeRightSharp = 2'd1;
  localparam logic [1:0] ModeLeftSharp = 2'd2;

  typedef enum logic [2:0] {
    StIdle, StRead, StSensor, StDivide, StPd, StMix, StOut
  } state_e;

  typedef struct packed {
    logic [7:0] prop_gain;
    logic [7:0] deriv_gain;
    logic [3:0] target_position;
    logic [7:0] max_speed;
    logic [6:0] threshold_percent;
  } cfg_t;

  typedef struct packed {
    logic       line_found;
    logic [3:0] position;
    logic [7:0] left_speed;
    logic [7:0] right_speed;
    logic [1:0] drive_mode;
    logic       right_edge;
    logic       left_edge;
  } result_t;
endpackage
`default_nettype wire

/* hdl/lsp_if.sv */
`timescale 1ns / 1ps
`default_nettype none
interface lsp_in_if #(
  parameter int unsigned NumSensors = 8,
  parameter int unsigned SampleBits = 10
);
  logic valid;
  logic ready;
  logic calibrate;
  logic [NumSensors-1:0][SampleBits-1:0] sample;
  modport source (output valid, calibrate, sample, input ready);
  modport sink (input valid, calibrate, sample, output ready);
endinterface

interface lsp_out_if;
  logic       valid;
  logic       ready;
  logic       line_found;
  logic [3:0] position;
  logic [7:0] left_speed;
  logic [7:0] right_speed;
  logic [1:0] drive_mode;
  logic       right_edge;
  logic       left_edge;
  modport source (output valid, line_found, position, left_speed, right_speed,
                  drive_mode, right_edge, left_edge, input ready);
  modport sink (input valid, line_found, position, left_speed, right_speed,
                drive_mode, right_edge, left_edge, output ready);
endinterface
`default_nettype wire

/* hdl/lsp_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
module lsp_ram #(
  parameter int unsigned Width = 20,
  parameter int unsigned Depth = 8
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

/* hdl/lsp_cal.sv */
`timescale 1ns / 1ps
`default_nettype none
// Per-sensor min/max store with a reset fill count. Entries at or above the
// count read as the reset range. Also computes one sensor's threshold test.
module lsp_cal
  import lsp_pkg::*;
#(
  parameter int unsigned NumSensors = NumSensorsDef,
  parameter int unsigned SampleBits = SampleBitsDef,
  localparam int unsigned IdxBits = $clog2(NumSensors)
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic [IdxBits-1:0]    raddr_i,
  input  wire logic [IdxBits-1:0]    waddr_i,
  input  wire logic                  calib_we_i,
  input  wire logic [SampleBits-1:0] sample_i,
  input  wire logic [6:0]            percent_i,
  output logic                       below_o
);
  localparam int unsigned W = 2 * SampleBits;
  localparam int unsigned PW = SampleBits + 10;
  localparam logic [SampleBits-1:0] MaxSample = {SampleBits{1'b1}};
  localparam logic signed [PW-1:0] Hundred = PW'(100);

  logic [W-1:0] rdata;
  logic [SampleBits-1:0] lo, hi, new_lo, new_hi;
  logic [IdxBits:0] fill_q, fill_d;
  logic valid_q;

  // Sensors are written in increasing order, so one count tracks validity.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      valid_q <= 1'b0;
    end else begin
      fill_q <= fill_d;
      valid_q <= ({1'b0, raddr_i} < fill_q) ||
                 (calib_we_i && waddr_i == raddr_i);
    end
  end

  always_comb begin
    fill_d = fill_q;
    if (calib_we_i && {1'b0, waddr_i} == fill_q) fill_d = fill_q + 1'b1;
  end

  assign lo = valid_q ? rdata[SampleBits-1:0] : MaxSample;
  assign hi = valid_q ? rdata[W-1:SampleBits] : '0;
  assign new_lo = (sample_i < lo) ? sample_i : lo;
  assign new_hi = (sample_i > hi) ? sample_i : hi;

  lsp_ram #(.Width(W), .Depth(NumSensors)) u_ram (
    .clk_i(clk_i), .we_i(calib_we_i), .waddr_i(waddr_i),
    .wdata_i({new_hi, new_lo}), .raddr_i(raddr_i), .rdata_o(rdata)
  );

  logic signed [SampleBits+1:0] span, diff;
  logic signed [PW-1:0] prod, scaled;
  always_comb begin
    span = $signed({2'b00, hi}) - $signed({2'b00, lo});
    diff = $signed({2'b00, sample_i}) - $signed({2'b00, lo});
    prod = span * $signed({1'b0, percent_i});
    scaled = PW'(diff) * Hundred;
    // The test sample < lo + prod / 100 is done by scaling the sample side.
    // The quotient rounds toward zero, so a negative product compares
    // strictly and a non-negative one needs a whole step of headroom.
    below_o = prod[PW-1] ? (scaled < prod) : (scaled + Hundred <= prod);
  end
endmodule
`default_nettype wire

/* hdl/lsp_pd.sv */
`timescale 1ns / 1ps
`default_nettype none
// PD error and response for one position.
module lsp_pd
  import lsp_pkg::*;
(
  input  wire logic [3:0]        pos_i,
  input  wire logic signed [4:0] last_err_i,
  input  wire cfg_t              cfg_i,
  output logic signed [4:0]      err_o,
  output logic signed [15:0]     resp_o
);
  logic signed [5:0] e, de;
  logic signed [15:0] e_w, de_w, kp_w, kd_w;
  always_comb begin
    e = $signed({2'b00, cfg_i.target_position}) - $signed({2'b00, pos_i});
    de = e - $signed({last_err_i[4], last_err_i});
    err_o = e[4:0];
    e_w = 16'(e);
    de_w = 16'(de);
    kp_w = $signed({8'd0, cfg_i.prop_gain});
    kd_w = $signed({8'd0, cfg_i.deriv_gain});
    resp_o = e_w * kp_w + de_w * kd_w;
  end
endmodule
`default_nettype wire

/* hdl/line_sensor_pd_steering.sv */
`timescale 1ns / 1ps
`default_nettype none
// Line sensor PD steering.
// in_if carries a calibrate flag and one sample per sensor; out_if returns
// one result per input transaction. cfg_we_i/cfg_idx_i/cfg_data_i write the
// gains, setpoint, top speed and threshold percent; write only when idle.
// Calibrate transactions widen each sensor's min/max range in a small
// memory; run transactions test every sensor against its threshold, average
// the inner hits into a position, form the PD response and mix speeds.
// A calibrate transaction passes a read step and then one step per sensor;
// a run with no line adds a divide step and keeps the held speeds, and a
// run with a line subtracts the hit count in the divide step once per cycle
// until the position is found, then passes the PD and mix steps. One item
// is in flight at a time; the block returns to idle in the cycle after the
// result is taken, so it takes no new item before the last result is taken.
// Reset restores register defaults, held drive 150/150 forward, error 0,
// and a fill count makes the store read as an empty range without clearing.
// When the receiver stalls the result holds in the output register.
module line_sensor_pd_steering
  import lsp_pkg::*;
#(
  parameter int unsigned NumSensors = NumSensorsDef,
  parameter int unsigned SampleBits = SampleBitsDef
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  lsp_in_if.sink                      in_if,
  lsp_out_if.source                   out_if,
  input  wire logic                   cfg_we_i,
  input  wire logic [CfgIdxBits-1:0]  cfg_idx_i,
  input  wire logic [CfgDataBits-1:0] cfg_data_i
);
  localparam int unsigned IdxBits = $clog2(NumSensors);
  localparam int unsigned SumBits = $clog2(2 * NumSensors * NumSensors);
  localparam logic [IdxBits-1:0] LastIdx = IdxBits'(NumSensors - 1);

  state_e state_q, state_d;
  cfg_t cfg_q;
  logic calib_q;
  logic [NumSensors-1:0][SampleBits-1:0] samp_q;
  logic [IdxBits-1:0] ridx_q, widx_q;
  logic [SumBits-1:0] sum_q, rem_q;
  logic [3:0] cnt_q, quo_q;
  logic redge_q, ledge_q;
  logic signed [4:0] last_err_q;
  logic [7:0] held_l_q, held_r_q;
  logic [1:0] held_m_q;
  logic signed [15:0] resp_q;
  result_t res_q;
  logic below, calib_we;
  logic signed [4:0] err;
  logic signed [15:0] resp;
  logic signed [15:0] m_s, over;
  logic [7:0] mix_l, mix_r;
  logic [1:0] mix_m;

  assign in_if.ready = (state_q == StIdle);
  assign out_if.valid = (state_q == StOut);
  assign out_if.line_found = res_q.line_found;
  assign out_if.position = res_q.position;
  assign out_if.left_speed = res_q.left_speed;
  assign out_if.right_speed = res_q.right_speed;
  assign out_if.drive_mode = res_q.drive_mode;
  assign out_if.right_edge = res_q.right_edge;
  assign out_if.left_edge = res_q.left_edge;

  assign calib_we = (state_q == StSensor) && calib_q;

  lsp_cal #(.NumSensors(NumSensors), .SampleBits(SampleBits)) u_cal (
    .clk_i(clk_i), .rst_ni(rst_ni), .raddr_i(ridx_q), .waddr_i(widx_q),
    .calib_we_i(calib_we), .sample_i(samp_q[widx_q]),
    .percent_i(cfg_q.threshold_percent), .below_o(below)
  );

  lsp_pd u_pd (.pos_i(quo_q), .last_err_i(last_err_q), .cfg_i(cfg_q),
               .err_o(err), .resp_o(resp));

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle:   if (in_if.valid) state_d = StRead;
      StRead:   state_d = StSensor;
      StSensor: if (widx_q == LastIdx) state_d = calib_q ? StOut : StDivide;
      StDivide: if (cnt_q == 4'd0) state_d = StOut;
                else if (rem_q < SumBits'(cnt_q)) state_d = StPd;
      StPd:     state_d = StMix;
      StMix:    state_d = StOut;
      StOut:    if (out_if.ready) state_d = StIdle;
      default:  state_d = StIdle;
    endcase
  end

  // An exact response of plus or minus the top speed stays in forward drive.
  always_comb begin
    m_s = $signed({8'd0, cfg_q.max_speed});
    over = 16'sd0;
    mix_m = ModeForward;
    mix_l = cfg_q.max_speed;
    mix_r = cfg_q.max_speed;
    if (resp_q > m_s) begin
      over = resp_q - m_s;
      mix_m = ModeRightSharp;
      mix_r = (over > m_s) ? cfg_q.max_speed : over[7:0];
    end else if (resp_q < -m_s) begin
      over = -resp_q - m_s;
      mix_m = ModeLeftSharp;
      mix_l = (over > m_s) ? cfg_q.max_speed : over[7:0];
    end else if (resp_q >= 16'sd0) begin
      mix_r = cfg_q.max_speed - resp_q[7:0];
    end else begin
      mix_l = cfg_q.max_speed + resp_q[7:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cfg_q <= '{prop_gain: 8'd64, deriv_gain: 8'd120, target_position: 4'd7,
                 max_speed: 8'd230, threshold_percent: 7'd50};
      last_err_q <= '0;
      held_l_q <= 8'd150;
      held_r_q <= 8'd150;
      held_m_q <= ModeForward;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegPropGain:  cfg_q.prop_gain <= cfg_data_i;
          RegDerivGain: cfg_q.deriv_gain <= cfg_data_i;
          RegTarget:    cfg_q.target_position <= cfg_data_i[3:0];
          RegMaxSpeed:  cfg_q.max_speed <= cfg_data_i;
          RegPercent:   cfg_q.threshold_percent <= cfg_data_i[6:0];
          default: ;
        endcase
      end
      if (state_q == StPd) last_err_q <= err;
      if (state_q == StMix) begin
        held_m_q <= mix_m;
        held_l_q <= mix_l;
        held_r_q <= mix_r;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      StIdle: begin
        calib_q <= in_if.calibrate;
        samp_q <= in_if.sample;
        ridx_q <= '0;
        widx_q <= '0;
        sum_q <= '0;
        cnt_q <= '0;
        redge_q <= 1'b0;
        ledge_q <= 1'b0;
      end
      StRead: ridx_q <= ridx_q + 1'b1;
      StSensor: begin
        widx_q <= widx_q + 1'b1;
        if (ridx_q != LastIdx || widx_q == LastIdx - 1'b1) ridx_q <= ridx_q + 1'b1;
        if (!calib_q && below) begin
          if (widx_q == '0) redge_q <= 1'b1;
          else if (widx_q == LastIdx) ledge_q <= 1'b1;
          else begin
            cnt_q <= cnt_q + 1'b1;
            sum_q <= sum_q + SumBits'({widx_q, 1'b0});
          end
        end
        // The left edge sensor never adds to the sum, so it is complete here.
        rem_q <= sum_q;
        quo_q <= '0;
      end
      StDivide: begin
        // Divide by repeated subtraction; the quotient is small.
        if (rem_q >= SumBits'(cnt_q) && cnt_q != 4'd0) begin
          rem_q <= rem_q - SumBits'(cnt_q);
          quo_q <= quo_q + 1'b1;
        end
      end
      StPd: resp_q <= resp;
      default: ;
    endcase
    if (state_d == StOut && state_q != StOut) begin
      res_q.line_found <= !calib_q && cnt_q != 4'd0;
      res_q.position <= (!calib_q && cnt_q != 4'd0) ? quo_q : 4'd0;
      res_q.right_edge <= !calib_q && redge_q;
      res_q.left_edge <= !calib_q && ledge_q;
      res_q.drive_mode <= (state_q == StMix) ? mix_m : held_m_q;
      res_q.left_speed <= (state_q == StMix) ? mix_l : held_l_q;
      res_q.right_speed <= (state_q == StMix) ? mix_r : held_r_q;
    end
  end
endmodule
`default_nettype wire

/* hdl/lsp_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "line_sensor_pd_steering_assert.svh"
module lsp_assert_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_ready_i,
  input wire logic       out_valid_i,
  input wire logic       out_ready_i,
  input wire logic       line_found_i,
  input wire logic [3:0] position_i,
  input wire logic [1:0] drive_mode_i
);
  // One item in flight: no input is taken while a result waits.
  `LSPD_ASSERT_IMP(a_excl, clk_i, rst_ni, out_valid_i, !in_ready_i)
  `LSPD_ASSERT_NEXT(a_take, clk_i, rst_ni, in_valid_i && in_ready_i, !in_ready_i)
  `LSPD_ASSERT_IMP(a_nopos, clk_i, rst_ni, out_valid_i && !line_found_i, position_i == 4'd0)
  `LSPD_ASSERT_IMP(a_mode, clk_i, rst_ni, out_valid_i, drive_mode_i != 2'd3)
  `LSPD_ASSERT_NEXT(a_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i)
endmodule

bind line_sensor_pd_steering lsp_assert_checker u_lsp_assert (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_valid_i(in_if.valid), .in_ready_i(in_if.ready),
  .out_valid_i(out_if.valid), .out_ready_i(out_if.ready),
  .line_found_i(out_if.line_found), .position_i(out_if.position),
  .drive_mode_i(out_if.drive_mode)
);
`default_nettype wire

/* tb/lsp_checker.sv */
`timescale 1ns / 1ps
module lsp_checker
  import lsp_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  lsp_in_if.sink                 in_mon,
  lsp_out_if.sink                out_mon,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxBits-1:0]  cfg_idx_i,
  input  logic [CfgDataBits-1:0] cfg_data_i,
  output int                     fail_count,
  output int                     pending_count,
  output int                     result_count,
  output int                     found_count
);
  cfg_t              cfg;
  logic [9:0]        lo_level [8];
  logic [9:0]        hi_level [8];
  logic signed [4:0] prev_err;
  logic [7:0]        drive_left;
  logic [7:0]        drive_right;
  logic [1:0]        drive_mode;
  result_t           steer_q [$];

  assign pending_count = steer_q.size();

  // The threshold uses the signed span and a division that truncates toward zero.
  function automatic logic is_dark(int idx, logic [9:0] smp);
    longint lo, span, thr;
    lo = lo_level[idx];
    span = longint'(hi_level[idx]) - lo;
    thr = lo + (span * longint'(cfg.threshold_percent)) / 100;
    return longint'(smp) < thr;
  endfunction

  function automatic void steer_mix(int resp);
    int m, rev;
    m = cfg.max_speed;
    if (resp > m) begin
      rev = (resp - m > m) ? m : resp - m;
      drive_mode = ModeRightSharp; drive_left = 8'(m); drive_right = 8'(rev);
    end else if (resp < -m) begin
      rev = (-resp - m > m) ? m : -resp - m;
      drive_mode = ModeLeftSharp; drive_left = 8'(rev); drive_right = 8'(m);
    end else if (resp >= 0) begin
      drive_mode = ModeForward; drive_left = 8'(m); drive_right = 8'(m - resp);
    end else begin
      drive_mode = ModeForward; drive_left = 8'(m + resp); drive_right = 8'(m);
    end
  endfunction

  function automatic result_t steer_predict(logic cal, logic [7:0][9:0] smp);
    result_t r;
    int cnt, sum, e, resp;
    r = '0;
    cnt = 0;
    sum = 0;
    if (cal) begin
      for (int i = 0; i < 8; i++) begin
        if (smp[i] > hi_level[i]) hi_level[i] = smp[i];
        if (smp[i] < lo_level[i]) lo_level[i] = smp[i];
      end
    end else begin
      for (int i = 0; i < 8; i++) begin
        if (is_dark(i, smp[i])) begin
          if (i == 0) r.right_edge = 1'b1;
          else if (i == 7) r.left_edge = 1'b1;
          else begin cnt++; sum += 2 * i; end
        end
      end
      if (cnt != 0) begin
        r.line_found = 1'b1;
        r.position = 4'(sum / cnt);
        e = int'(cfg.target_position) - int'(r.position);
        resp = int'(cfg.prop_gain) * e + int'(cfg.deriv_gain) * (e - int'(prev_err));
        prev_err = 5'(e);
        steer_mix(resp);
      end
    end
    r.left_speed = drive_left;
    r.right_speed = drive_right;
    r.drive_mode = drive_mode;
    return r;
  endfunction

  task automatic check_field(string name, int exp_v, int act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_t r;
    if (!rst_ni) begin
      cfg = '{prop_gain: 8'd64, deriv_gain: 8'd120, target_position: 4'd7,
              max_speed: 8'd230, threshold_percent: 7'd50};
      for (int i = 0; i < 8; i++) begin
        lo_level[i] = 10'd1023;
        hi_level[i] = 10'd0;
      end
      prev_err = '0;
      drive_left = 8'd150;
      drive_right = 8'd150;
      drive_mode = ModeForward;
      steer_q.delete();
      fail_count = 0;
      result_count = 0;
      found_count = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegPropGain:  cfg.prop_gain = cfg_data_i;
          RegDerivGain: cfg.deriv_gain = cfg_data_i;
          RegTarget:    cfg.target_position = cfg_data_i[3:0];
          RegMaxSpeed:  cfg.max_speed = cfg_data_i;
          RegPercent:   cfg.threshold_percent = cfg_data_i[6:0];
          default: ;
        endcase
      end
      if (out_mon.valid && out_mon.ready) begin
        result_count++;
        if (steer_q.size() == 0) begin
          $error("result transaction with no expectation waiting");
          fail_count++;
        end else begin
          r = steer_q.pop_front();
          if (r.line_found) found_count++;
          check_field("line_found", r.line_found, out_mon.line_found);
          check_field("position", r.position, out_mon.position);
          check_field("left_speed", r.left_speed, out_mon.left_speed);
          check_field("right_speed", r.right_speed, out_mon.right_speed);
          check_field("drive_mode", r.drive_mode, out_mon.drive_mode);
          check_field("right_edge", r.right_edge, out_mon.right_edge);
          check_field("left_edge", r.left_edge, out_mon.left_edge);
        end
      end
      if (in_mon.valid && in_mon.ready)
        steer_q.push_back(steer_predict(in_mon.calibrate, in_mon.sample));
    end
  end
endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
module tb;
  import lsp_pkg::*;

  localparam int StallLimit = 5000;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [CfgIdxBits-1:0]  cfg_idx_i;
  logic [CfgDataBits-1:0] cfg_data_i;
  int                     fail_count;
  int                     pending_count;
  int                     result_count;
  int                     found_count;
  int                     idle_cycles = 0;
  bit                     no_gaps;
  int                     sent_count;

  lsp_in_if  scan_if ();
  lsp_out_if steer_if ();

  line_sensor_pd_steering dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_if(scan_if.sink), .out_if(steer_if.source),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_data_i(cfg_data_i)
  );

  lsp_checker chk (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_mon(scan_if.sink), .out_mon(steer_if.sink),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_data_i(cfg_data_i),
    .fail_count(fail_count), .pending_count(pending_count),
    .result_count(result_count), .found_count(found_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Receiver stalls at random except during the quiet stretch.
  always @(negedge clk_i) begin
    steer_if.ready <= no_gaps || ($urandom_range(99) >= 28);
  end

  // Watchdog: counts cycles without any accepted transaction.
  always @(posedge clk_i) begin
    if ((scan_if.valid && scan_if.ready) || (steer_if.valid && steer_if.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > StallLimit) begin
      $display("watchdog expired after %0d items", sent_count);
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic write_reg(logic [CfgIdxBits-1:0] idx, int val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= CfgDataBits'(val);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain();
    scan_if.valid <= 1'b0;
    while (pending_count != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  // Valid stays up after an acceptance until the next transaction or an idle
  // cycle replaces it; the block is busy in between.
  task automatic send_scan(logic cal, logic [7:0][9:0] smp);
    while (!no_gaps && $urandom_range(99) < 28) begin
      scan_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    scan_if.valid <= 1'b1;
    scan_if.calibrate <= cal;
    scan_if.sample <= smp;
    @(posedge clk_i);
    while (!scan_if.ready) @(posedge clk_i);
    sent_count++;
    @(negedge clk_i);
  endtask

  // Inner sensors chosen by the mask read dark, the others bright; edges too.
  function automatic logic [7:0][9:0] line_scan(logic [7:0] dark);
    logic [7:0][9:0] s;
    for (int i = 0; i < 8; i++)
      s[i] = dark[i] ? 10'($urandom_range(300)) : 10'($urandom_range(1023, 700));
    return s;
  endfunction

  function automatic logic [7:0][9:0] rand_scan();
    logic [7:0][9:0] s;
    for (int i = 0; i < 8; i++) s[i] = 10'($urandom_range(1023));
    return s;
  endfunction

  task automatic calibrate_sweep(int n);
    logic [7:0][9:0] s;
    for (int k = 0; k < n; k++) begin
      for (int i = 0; i < 8; i++)
        s[i] = (k % 2) ? 10'($urandom_range(1023, 800)) : 10'($urandom_range(150));
      send_scan(1'b1, s);
    end
  endtask

  initial begin
    logic [7:0][9:0] s;
    int phase_cfg [5][5];
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = RegPropGain;
    cfg_data_i = '0;
    scan_if.valid = 1'b0;
    scan_if.calibrate = 1'b0;
    scan_if.sample = '0;
    no_gaps = 1'b0;
    sent_count = 0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: uncalibrated range, extremes, then calibrated line cases.
    send_scan(1'b0, '0);
    send_scan(1'b0, {8{10'd1023}});
    send_scan(1'b1, '0);
    send_scan(1'b0, {8{10'd1023}});
    send_scan(1'b1, {8{10'd1023}});
    send_scan(1'b0, {8{10'h155}});
    send_scan(1'b0, {8{10'h2aa}});
    send_scan(1'b0, line_scan(8'b0000_0010));
    send_scan(1'b0, line_scan(8'b0100_0000));
    send_scan(1'b0, line_scan(8'b1000_0001));
    send_scan(1'b0, line_scan(8'b0111_1110));
    send_scan(1'b0, line_scan(8'b0001_1000));
    send_scan(1'b0, line_scan(8'b1110_0000));
    send_scan(1'b0, line_scan(8'b0000_0111));
    drain();

    // Settings: prop, deriv, target, max speed, percent.
    phase_cfg = '{'{255, 255, 12, 255, 100}, '{0, 0, 2, 0, 0},
                  '{255, 255, 0, 40, 127}, '{20, 200, 15, 1, 75},
                  '{64, 120, 7, 230, 50}};
    for (int p = 0; p < 5; p++) begin
      write_reg(RegPropGain, phase_cfg[p][0]);
      write_reg(RegDerivGain, phase_cfg[p][1]);
      write_reg(RegTarget, phase_cfg[p][2]);
      write_reg(RegMaxSpeed, phase_cfg[p][3]);
      write_reg(RegPercent, phase_cfg[p][4]);
      no_gaps = (p == 2);
      for (int k = 0; k < 96; k++) begin
        case ($urandom_range(9))
          0:       send_scan(1'b1, rand_scan());
          1, 2:    send_scan(1'b0, rand_scan());
          default: send_scan(1'b0, line_scan(8'($urandom)));
        endcase
      end
      calibrate_sweep(2);
      drain();
    end
    drain();
    no_gaps = 1'b0;

    $display("%0d scans sent, %0d results checked, %0d with a line found",
             sent_count, result_count, found_count);
    if (fail_count == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end
endmodule

/* files.f */
+incdir+hdl
hdl/lsp_pkg.sv
hdl/lsp_if.sv
hdl/lsp_ram.sv
hdl/lsp_cal.sv
hdl/lsp_pd.sv
hdl/line_sensor_pd_steering.sv
hdl/lsp_checker.sv
tb/lsp_checker.sv
tb/tb.sv
